### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off by rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define GUKF_ASSERT_IMPLY(lbl, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error(msg);

// next-cycle implication
`define GUKF_ASSERT_NEXT(lbl, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error(msg);

`else

`define GUKF_ASSERT_IMPLY(lbl, a, b, msg)

`define GUKF_ASSERT_NEXT(lbl, a, b, msg)

`endif

`endif

### hw/rtl/gukf_pkg.sv
// ----------------------------------------------------------------------------
// gukf_pkg
// Widths, register indexes, controller states and control structs.
// ----------------------------------------------------------------------------
package gukf_pkg;

    localparam int COORD_W    = 12;
    localparam int CELL_W     = 10;
    localparam int CNT_W      = 8;
    localparam int TOTAL_W    = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int EPOCH_W    = 8;
    localparam int DIV_STEPS  = 12;
    localparam int DIV_CNT_W  = 4;
    localparam int LANES      = 4;

    // divider lanes
    localparam int LANE_X = 0;
    localparam int LANE_Y = 1;
    localparam int LANE_H = 2;
    localparam int LANE_W = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PER_CELL_CAP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_CAP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd4;

    // register reset values
    localparam logic [CELL_W-1:0]  RST_CELL_SIZE    = 10'd32;
    localparam logic [CNT_W-1:0]   RST_PER_CELL_CAP = 8'd4;
    localparam logic [TOTAL_W-1:0] RST_TOTAL_CAP    = 12'd1000;
    localparam logic [COORD_W-1:0] RST_IMAGE_HEIGHT = 12'd480;
    localparam logic [COORD_W-1:0] RST_IMAGE_WIDTH  = 12'd640;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    typedef enum logic [2:0] {
        S_RST_CLR,
        S_IDLE,
        S_START,
        S_FRM_CLR,
        S_DIV,
        S_IDX,
        S_READ,
        S_DECIDE
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic frame_start;
        logic clr_write;
        logic div_step;
        logic idx_load;
        logic ram_read;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic epoch_wrap;
        logic clr_last;
        logic div_last;
    } dp_status_t;

endpackage

### hw/rtl/gukf_if.sv
// ----------------------------------------------------------------------------
// gukf channel interfaces
// Valid/ready channels for keypoints in and keep decisions out.
// ----------------------------------------------------------------------------
interface gukf_kp_if import gukf_pkg::*;;

    logic               valid;
    logic               ready;
    logic               start_of_frame;
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;

    modport source (output valid, output start_of_frame, output point_x,
                    output point_y, input ready);
    modport sink   (input valid, input start_of_frame, input point_x,
                    input point_y, output ready);
endinterface

interface gukf_dec_if import gukf_pkg::*;;

    logic               valid;
    logic               ready;
    logic               keep;
    logic [TOTAL_W-1:0] kept_count;

    modport source (output valid, output keep, output kept_count, input ready);
    modport sink   (input valid, input keep, input kept_count, output ready);
endinterface

### hw/rtl/gukf_ram.sv
// ----------------------------------------------------------------------------
// gukf_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gukf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/gukf_datapath.sv
// ----------------------------------------------------------------------------
// gukf_datapath
// Config registers, four-lane serial divider, cell index, count store, totals.
// ----------------------------------------------------------------------------
module gukf_datapath import gukf_pkg::*; #(
    parameter int MAX_GRID_ROWS = 32,
    parameter int MAX_GRID_COLS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  start_of_frame,
    input  logic [COORD_W-1:0]    point_x,
    input  logic [COORD_W-1:0]    point_y,
    input  ctrl_cmd_t             cmd,
    output dp_status_t            status,
    output logic                  keep,
    output logic [TOTAL_W-1:0]    kept_count
);

    localparam int GRID_CELLS = MAX_GRID_ROWS * MAX_GRID_COLS;
    localparam int ADDR_W     = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
    localparam int ROW_W      = (MAX_GRID_ROWS > 1) ? $clog2(MAX_GRID_ROWS) : 1;
    localparam int COL_W      = (MAX_GRID_COLS > 1) ? $clog2(MAX_GRID_COLS) : 1;
    localparam int WORD_W     = EPOCH_W + CNT_W;

    // configuration
    logic [CELL_W-1:0]  cell_size_reg;
    logic [CNT_W-1:0]   per_cell_cap_reg;
    logic [TOTAL_W-1:0] total_cap_reg;
    logic [COORD_W-1:0] image_height_reg;
    logic [COORD_W-1:0] image_width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_size_reg    <= RST_CELL_SIZE;
            per_cell_cap_reg <= RST_PER_CELL_CAP;
            total_cap_reg    <= RST_TOTAL_CAP;
            image_height_reg <= RST_IMAGE_HEIGHT;
            image_width_reg  <= RST_IMAGE_WIDTH;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_CELL_SIZE:    cell_size_reg    <= cfg_data[CELL_W-1:0];
                REG_PER_CELL_CAP: per_cell_cap_reg <= cfg_data[CNT_W-1:0];
                REG_TOTAL_CAP:    total_cap_reg    <= cfg_data[TOTAL_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[COORD_W-1:0];
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    // restoring divider, one quotient bit per lane per step;
    // dividend register turns into the quotient as it shifts
    logic [COORD_W-1:0]   dvd_reg  [LANES];
    logic [COORD_W-1:0]   dvd_next [LANES];
    logic [CELL_W-1:0]    rem_reg  [LANES];
    logic [CELL_W-1:0]    rem_next [LANES];
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic                 sof_reg;

    always_comb
    begin
        logic [CELL_W:0] rem_sh;
        logic [CELL_W:0] diff;
        logic            ge;
        for (int l = 0; l < LANES; l++)
        begin
            rem_sh = {rem_reg[l], dvd_reg[l][COORD_W-1]};
            diff   = rem_sh - {1'b0, cell_size_reg};
            ge     = (rem_sh >= {1'b0, cell_size_reg});
            rem_next[l] = ge ? diff[CELL_W-1:0] : rem_sh[CELL_W-1:0];
            dvd_next[l] = {dvd_reg[l][COORD_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.load)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sof_reg         <= start_of_frame;
            dvd_reg[LANE_X] <= point_x;
            dvd_reg[LANE_Y] <= point_y;
            dvd_reg[LANE_H] <= image_height_reg;
            dvd_reg[LANE_W] <= image_width_reg;
            for (int l = 0; l < LANES; l++)
            begin
                rem_reg[l] <= '0;
            end
        end
        else if (cmd.div_step)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                dvd_reg[l] <= dvd_next[l];
                rem_reg[l] <= rem_next[l];
            end
        end
    end

    // grid extent and clamped cell
    logic [ROW_W-1:0]  rows_m1;
    logic [COL_W-1:0]  cols_m1;
    logic [ROW_W-1:0]  row_sel;
    logic [COL_W-1:0]  col_sel;
    logic [ADDR_W:0]   idx_wide;
    logic [ADDR_W-1:0] idx_reg;

    always_comb
    begin
        if (dvd_reg[LANE_H] == '0)
            rows_m1 = '0;
        else if (dvd_reg[LANE_H] >= COORD_W'(MAX_GRID_ROWS))
            rows_m1 = ROW_W'(MAX_GRID_ROWS - 1);
        else
            rows_m1 = ROW_W'(dvd_reg[LANE_H] - COORD_W'(1));

        if (dvd_reg[LANE_W] == '0)
            cols_m1 = '0;
        else if (dvd_reg[LANE_W] >= COORD_W'(MAX_GRID_COLS))
            cols_m1 = COL_W'(MAX_GRID_COLS - 1);
        else
            cols_m1 = COL_W'(dvd_reg[LANE_W] - COORD_W'(1));

        row_sel = (dvd_reg[LANE_Y] > COORD_W'(rows_m1)) ? rows_m1
                                                        : ROW_W'(dvd_reg[LANE_Y]);
        col_sel = (dvd_reg[LANE_X] > COORD_W'(cols_m1)) ? cols_m1
                                                        : COL_W'(dvd_reg[LANE_X]);
        idx_wide = (ADDR_W+1)'(row_sel) * (ADDR_W+1)'(MAX_GRID_COLS)
                 + (ADDR_W+1)'(col_sel);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.idx_load)
        begin
            idx_reg <= idx_wide[ADDR_W-1:0];
        end
    end

    // frame epoch, kept total, clear sweep
    logic [EPOCH_W-1:0] epoch_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W-1:0] total_next;
    logic [ADDR_W-1:0]  clr_addr_reg;

    // count store: each word holds the epoch of its last write and the count
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] ram_rdata;

    logic             disabled;
    logic             tag_hit;
    logic [CNT_W-1:0] cell_count;
    logic             pass;
    logic             keep_now;

    always_comb
    begin
        disabled   = (cell_size_reg == '0) || (per_cell_cap_reg == '0)
                  || (total_cap_reg == '0);
        tag_hit    = (ram_rdata[WORD_W-1:CNT_W] == epoch_reg);
        cell_count = tag_hit ? ram_rdata[CNT_W-1:0] : '0;
        pass       = (cell_count < per_cell_cap_reg) && (total_reg < total_cap_reg);
        keep_now   = disabled || pass;

        if (disabled)
            total_next = (total_reg != TOTAL_MAX) ? total_reg + TOTAL_W'(1) : total_reg;
        else if (pass)
            total_next = total_reg + TOTAL_W'(1);
        else
            total_next = total_reg;

        ram_we    = cmd.clr_write || (cmd.commit && !disabled && pass);
        ram_waddr = cmd.clr_write ? clr_addr_reg : idx_reg;
        ram_wdata = cmd.clr_write ? '0 : {epoch_reg, cell_count + CNT_W'(1)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epoch_reg    <= '0;
            total_reg    <= '0;
            clr_addr_reg <= '0;
        end
        else
        begin
            if (cmd.frame_start && sof_reg)
            begin
                // epoch wraps to zero exactly when the store is swept back to zero
                epoch_reg <= epoch_reg + EPOCH_W'(1);
                total_reg <= '0;
            end
            else if (cmd.commit)
            begin
                total_reg <= total_next;
            end
            if (cmd.clr_write)
            begin
                clr_addr_reg <= status.clr_last ? '0 : clr_addr_reg + ADDR_W'(1);
            end
        end
    end

    gukf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (GRID_CELLS)
    ) u_counts (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.ram_read),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // result payload
    logic               keep_reg;
    logic [TOTAL_W-1:0] kept_count_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            keep_reg       <= keep_now;
            kept_count_reg <= total_next;
        end
    end

    assign keep       = keep_reg;
    assign kept_count = kept_count_reg;

    assign status.epoch_wrap = sof_reg && (&epoch_reg);
    assign status.clr_last   = (clr_addr_reg == ADDR_W'(GRID_CELLS - 1));
    assign status.div_last   = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));

endmodule

### hw/rtl/gukf_ctrl.sv
// ----------------------------------------------------------------------------
// gukf_ctrl
// Sequencer for count clear, accept, frame start, divide, index, read and decide.
// ----------------------------------------------------------------------------
module gukf_ctrl import gukf_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RST_CLR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;

        case (state_reg)
            S_RST_CLR:
            begin
                cmd.clr_write = 1'b1;
                if (status.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                cmd.frame_start = 1'b1;
                state_next      = status.epoch_wrap ? S_FRM_CLR : S_DIV;
            end
            S_FRM_CLR:
            begin
                cmd.clr_write = 1'b1;
                if (status.clr_last)
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                    state_next = S_IDX;
            end
            S_IDX:
            begin
                cmd.idx_load = 1'b1;
                state_next   = S_READ;
            end
            S_READ:
            begin
                cmd.ram_read = 1'b1;
                state_next   = S_DECIDE;
            end
            S_DECIDE:
            begin
                // hold the decision until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

### hw/rtl/grid_uniform_keypoint_filter_top.sv
// ----------------------------------------------------------------------------
// grid_uniform_keypoint_filter_top
// Keeps keypoints per grid cell and per frame up to programmable caps.
//
//   channel    dir  payload                              beat when
//   keypoint   in   start_of_frame, point_x, point_y     valid && ready
//   decision   out  keep, kept_count                     valid && ready
//   cfg        in   cfg_index, cfg_data                  cfg_wr_en
//
// Each keypoint runs accept, frame start, 12 steps of the four-lane serial
// divider, index, count read and decide before the next one is accepted.
// After reset all MAX_GRID_ROWS*MAX_GRID_COLS words of the count store are
// cleared before the first keypoint; the same sweep runs inside the item
// on every 256th start of frame, when the frame epoch wraps.
// A result waiting in the output register holds only the next decide step.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module grid_uniform_keypoint_filter_top import gukf_pkg::*; #(
    parameter int MAX_GRID_ROWS = 32,
    parameter int MAX_GRID_COLS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    gukf_kp_if.sink               keypoint,
    gukf_dec_if.source            decision
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    gukf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (keypoint.valid),
        .in_ready  (keypoint.ready),
        .out_valid (decision.valid),
        .out_ready (decision.ready),
        .status    (status),
        .cmd       (cmd)
    );

    gukf_datapath #(
        .MAX_GRID_ROWS (MAX_GRID_ROWS),
        .MAX_GRID_COLS (MAX_GRID_COLS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .start_of_frame (keypoint.start_of_frame),
        .point_x        (keypoint.point_x),
        .point_y        (keypoint.point_y),
        .cmd            (cmd),
        .status         (status),
        .keep           (decision.keep),
        .kept_count     (decision.kept_count)
    );

    `GUKF_ASSERT_NEXT(a_busy_after_accept, keypoint.valid && keypoint.ready,
        !keypoint.ready, "keypoint accepted while previous item in progress")
    `GUKF_ASSERT_IMPLY(a_clear_exclusive, cmd.clr_write,
        !cmd.commit && !keypoint.ready, "count sweep overlaps a decision or an accept")
    `GUKF_ASSERT_NEXT(a_commit_shows, cmd.commit, decision.valid,
        "decision committed but output not valid")
    `GUKF_ASSERT_IMPLY(a_commit_room, cmd.commit, !decision.valid || decision.ready,
        "decision overwrites a beat not yet taken")

endmodule
